>>> hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, constants and helpers of the nearest palette hue classifier.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int NUM_REFS_DEFAULT    = 5;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int REF_REG_COUNT       = 5;

    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;
    localparam int HUE_W       = 15;
    localparam int DIST_W      = 14;
    localparam int CLASS_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = COLOR_W;
    localparam int QUOT_W      = 12;
    localparam int DIVIDEND_W  = 20;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [HUE_W-1:0]  HUE_FULL       = 15'd23040;
    localparam logic [HUE_W-1:0]  HUE_BASE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0]  HUE_BASE_BLUE  = 15'd15360;
    localparam logic [DIST_W-1:0] HUE_HALF       = 14'd11520;

    localparam logic [CFG_INDEX_W-1:0] REG_REF_BASE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAT_THRESHOLD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VAL_THRESHOLD = 3'd6;

    localparam logic [CHAN_W-1:0] SAT_RESET = 8'd18;
    localparam logic [CHAN_W-1:0] VAL_RESET = 8'd51;

    localparam logic [COLOR_W-1:0] REF_RESET [REF_REG_COUNT] = '{
        24'hE4E1AE, 24'h95B5CA, 24'h8E8985, 24'hC27B65, 24'h89AB92
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [DIST_W-1:0]  best_distance;
    } result_t;

    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_t;

    typedef struct packed {
        logic             accepted;
        logic             last;
        logic [HUE_W-1:0] hue;
    } queue_entry_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chroma;
        logic [CHAN_W-1:0] maxv;
        logic [HUE_W-1:0]  base;
        logic              neg;
        logic [CHAN_W-1:0] diff;
    } hue_prep_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_DIV,
        H_DONE
    } hue_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_REFRESH,
        F_CHECK,
        F_HUE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_UPDATE,
        B_SEARCH
    } back_state_t;

    // max/min ties go to red, then green, then blue
    function automatic hue_prep_t hue_prep(input rgb_t px);
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] z;
        hue_prep_t         p;
        mx = px.red;
        if (px.green > mx) mx = px.green;
        if (px.blue > mx)  mx = px.blue;
        mn = px.red;
        if (px.green < mn) mn = px.green;
        if (px.blue < mn)  mn = px.blue;
        if (px.red == mx)
        begin
            p.base = '0;
            a      = px.green;
            z      = px.blue;
        end
        else if (px.green == mx)
        begin
            p.base = HUE_BASE_GREEN;
            a      = px.blue;
            z      = px.red;
        end
        else
        begin
            p.base = HUE_BASE_BLUE;
            a      = px.red;
            z      = px.green;
        end
        p.chroma = mx - mn;
        p.maxv   = mx;
        p.neg    = (a < z);
        p.diff   = p.neg ? (z - a) : (a - z);
        return p;
    endfunction

endpackage

>>> hdl/npc_hue.sv
// ----------------------------------------------------------------------------
// npc_hue
// Hexcone hue unit: restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npc_hue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  npc_pkg::rgb_t              color,
    output logic                       done,
    output logic [npc_pkg::HUE_W-1:0]  hue
);
    import npc_pkg::*;

    hue_state_t             state_reg, state_next;
    logic [DIVIDEND_W-1:0]  rem_reg, dsr_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [HUE_W-1:0]       base_reg;
    logic                   neg_reg, zero_reg;

    hue_prep_t              prep;
    logic [DIVIDEND_W-1:0]  dividend;
    logic                   ge;
    logic                   load;
    logic [HUE_W:0]         wrap;

    assign prep     = hue_prep(color);
    // 3840 * diff = (diff << 12) - (diff << 8)
    assign dividend = (DIVIDEND_W'(prep.diff) << 12) - (DIVIDEND_W'(prep.diff) << 8);
    assign ge       = (rem_reg >= dsr_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                    state_next = (prep.chroma == '0) ? H_DONE : H_DIV;
            end
            H_DIV:
            begin
                if (step_reg == '0)
                    state_next = H_DONE;
            end
            H_DONE:  state_next = H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        load = (state_reg == H_IDLE) && start;
        done = (state_reg == H_DONE);
        wrap = {1'b0, base_reg} + {1'b0, HUE_FULL} - (HUE_W + 1)'(quot_reg);
        if (wrap >= {1'b0, HUE_FULL})
            wrap = wrap - {1'b0, HUE_FULL};
        if (zero_reg)
            hue = '0;
        else if (!neg_reg)
            hue = base_reg + HUE_W'(quot_reg);
        else
            hue = wrap[HUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= H_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= dividend;
            dsr_reg  <= DIVIDEND_W'(prep.chroma) << (DIV_STEPS - 1);
            quot_reg <= '0;
            step_reg <= STEP_W'(DIV_STEPS - 1);
            base_reg <= prep.base;
            neg_reg  <= prep.neg;
            zero_reg <= (prep.chroma == '0);
        end
        else if (state_reg == H_DIV)
        begin
            if (ge)
                rem_reg <= rem_reg - dsr_reg;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

endmodule

>>> hdl/npc_front.sv
// ----------------------------------------------------------------------------
// npc_front
// Front end: configuration, reference hue cache, item hue and screening.
// ----------------------------------------------------------------------------
module npc_front #(
    parameter int NUM_REFS = npc_pkg::NUM_REFS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  npc_pkg::item_t             item,
    output logic                       busy,
    input  npc_pkg::cfg_t              cfg,
    output logic                       push,
    output npc_pkg::queue_entry_t      push_data,
    input  logic                       full,
    output logic [npc_pkg::HUE_W-1:0]  hue_table [NUM_REFS]
);
    import npc_pkg::*;

    localparam int COLOR_REGS = (NUM_REFS < REF_REG_COUNT) ? NUM_REFS : REF_REG_COUNT;
    localparam int SEL_W      = $clog2(COLOR_REGS);

    front_state_t      state_reg, state_next;
    item_t             item_reg;
    logic [COLOR_W-1:0] color_reg [COLOR_REGS];
    logic [HUE_W-1:0]  table_reg [COLOR_REGS];
    logic [CHAN_W-1:0] sat_reg, val_reg;
    logic [COLOR_REGS-1:0] dirty_reg, dirty_next;
    logic [SEL_W-1:0]  refsel_reg, ref_sel;
    queue_entry_t      entry_reg, entry_next;

    rgb_t              item_rgb, hue_color;
    hue_prep_t         item_prep;
    logic [2*CHAN_W-1:0] sat_lhs, sat_rhs;
    logic              pass;
    logic              hue_start, hue_done;
    logic [HUE_W-1:0]  hue_value;
    logic              launch, load_item, table_write;

    npc_hue u_hue (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hue_start),
        .color (hue_color),
        .done  (hue_done),
        .hue   (hue_value)
    );

    assign item_rgb  = '{red: item_reg.red, green: item_reg.green, blue: item_reg.blue};
    assign item_prep = hue_prep(item_rgb);
    // chroma * 255 against threshold * max
    assign sat_lhs   = {item_prep.chroma, {CHAN_W{1'b0}}} - (2 * CHAN_W)'(item_prep.chroma);
    assign sat_rhs   = (2 * CHAN_W)'(sat_reg) * (2 * CHAN_W)'(item_prep.maxv);
    assign pass      = (item_prep.chroma != '0) && (sat_lhs > sat_rhs)
                       && (item_prep.maxv > val_reg);

    always_comb
    begin
        ref_sel = '0;
        for (int i = COLOR_REGS - 1; i >= 0; i--)
        begin
            if (dirty_reg[i])
                ref_sel = SEL_W'(i);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (dirty_reg != '0)
                    state_next = F_REFRESH;
                else if (start)
                    state_next = F_CHECK;
            end
            F_REFRESH:
            begin
                if (hue_done)
                    state_next = F_IDLE;
            end
            F_CHECK:  state_next = pass ? F_HUE : F_PUSH;
            F_HUE:
            begin
                if (hue_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        hue_start   = 1'b0;
        hue_color   = item_rgb;
        launch      = 1'b0;
        load_item   = 1'b0;
        table_write = 1'b0;
        push        = 1'b0;
        entry_next  = entry_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (dirty_reg != '0)
                begin
                    hue_start = 1'b1;
                    hue_color = rgb_t'(color_reg[ref_sel]);
                    launch    = 1'b1;
                end
                else if (start)
                    load_item = 1'b1;
            end
            F_REFRESH: table_write = hue_done;
            F_CHECK:
            begin
                hue_start           = pass;
                entry_next.accepted = pass;
                entry_next.last     = item_reg.last;
                entry_next.hue      = '0;
            end
            F_HUE:
            begin
                if (hue_done)
                    entry_next.hue = hue_value;
            end
            F_PUSH:   push = !full;
            default:  push = 1'b0;
        endcase
    end

    always_comb
    begin
        dirty_next = dirty_reg;
        if (launch)
            dirty_next[ref_sel] = 1'b0;
        for (int i = 0; i < COLOR_REGS; i++)
        begin
            if (cfg.write && cfg.index == REG_REF_BASE + CFG_INDEX_W'(i))
                dirty_next[i] = 1'b1;
        end
    end

    assign busy      = (state_reg != F_IDLE) || (dirty_reg != '0);
    assign push_data = entry_reg;

    for (genvar i = 0; i < NUM_REFS; i++)
    begin : g_table
        if (i < COLOR_REGS)
        begin : g_reg
            assign hue_table[i] = table_reg[i];
        end
        else
        begin : g_black
            assign hue_table[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dirty_reg <= '1;
            sat_reg   <= SAT_RESET;
            val_reg   <= VAL_RESET;
            for (int i = 0; i < COLOR_REGS; i++)
                color_reg[i] <= REF_RESET[i];
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            if (cfg.write && cfg.index == REG_SAT_THRESHOLD)
                sat_reg <= cfg.data[CHAN_W-1:0];
            if (cfg.write && cfg.index == REG_VAL_THRESHOLD)
                val_reg <= cfg.data[CHAN_W-1:0];
            for (int i = 0; i < COLOR_REGS; i++)
            begin
                if (cfg.write && cfg.index == REG_REF_BASE + CFG_INDEX_W'(i))
                    color_reg[i] <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
            item_reg <= item;
        if (launch)
            refsel_reg <= ref_sel;
        if (table_write)
            table_reg[refsel_reg] <= hue_value;
        entry_reg <= entry_next;
    end

endmodule

>>> hdl/npc_queue.sv
// ----------------------------------------------------------------------------
// npc_queue
// Short FIFO of screened items between front and back end.
// ----------------------------------------------------------------------------
module npc_queue #(
    parameter int DEPTH = npc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  npc_pkg::queue_entry_t  push_data,
    output logic                   full,
    input  logic                   pop,
    output npc_pkg::queue_entry_t  head,
    output logic                   empty
);
    import npc_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    queue_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/npc_back.sv
// ----------------------------------------------------------------------------
// npc_back
// Back end: per-reference minimum hue distance and nearest-reference search.
// ----------------------------------------------------------------------------
module npc_back #(
    parameter int NUM_REFS = npc_pkg::NUM_REFS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  npc_pkg::queue_entry_t      head,
    input  logic                       empty,
    output logic                       pop,
    input  logic [npc_pkg::HUE_W-1:0]  hue_table [NUM_REFS],
    output logic                       done,
    output npc_pkg::result_t           result
);
    import npc_pkg::*;

    localparam int IDX_W = $clog2(NUM_REFS);

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, bidx_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic               last_reg;
    logic [DIST_W-1:0]  mins_reg [NUM_REFS];
    logic [DIST_W-1:0]  best_reg;
    logic               done_reg;
    result_t            result_reg;

    logic [HUE_W-1:0]   href, dh, alt;
    logic [DIST_W-1:0]  hue_dist, cur_min;
    logic               last_ref, better;
    logic               upd_en, search_init, finish;

    assign href     = hue_table[idx_reg];
    assign cur_min  = mins_reg[idx_reg];
    assign dh       = (hue_reg > href) ? (hue_reg - href) : (href - hue_reg);
    assign alt      = HUE_FULL - dh;
    assign hue_dist = (alt < dh) ? alt[DIST_W-1:0] : dh[DIST_W-1:0];
    assign last_ref = (idx_reg == IDX_W'(NUM_REFS - 1));
    assign better   = (cur_min < best_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    if (head.accepted)
                        state_next = B_UPDATE;
                    else if (head.last)
                        state_next = B_SEARCH;
                end
            end
            B_UPDATE:
            begin
                if (last_ref)
                    state_next = last_reg ? B_SEARCH : B_IDLE;
            end
            B_SEARCH:
            begin
                if (last_ref)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        upd_en      = 1'b0;
        search_init = 1'b0;
        finish      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop         = !empty;
                search_init = !empty && !head.accepted && head.last;
            end
            B_UPDATE:
            begin
                upd_en      = (hue_dist < cur_min);
                search_init = last_ref && last_reg;
            end
            B_SEARCH: finish = last_ref;
            default:  pop    = 1'b0;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_REFS; i++)
                mins_reg[i] <= HUE_HALF;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (finish)
            begin
                for (int i = 0; i < NUM_REFS; i++)
                    mins_reg[i] <= HUE_HALF;
            end
            else if (upd_en)
                mins_reg[idx_reg] <= hue_dist;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hue_reg  <= head.hue;
            last_reg <= head.last;
        end
        if (search_init)
        begin
            idx_reg  <= IDX_W'(1);
            best_reg <= mins_reg[0];
            bidx_reg <= '0;
        end
        else if (pop)
            idx_reg <= '0;
        else if (state_reg == B_UPDATE || state_reg == B_SEARCH)
            idx_reg <= idx_reg + 1'b1;
        if (state_reg == B_SEARCH && better)
        begin
            best_reg <= cur_min;
            bidx_reg <= idx_reg;
        end
        if (finish)
        begin
            result_reg.class_index   <= better ? CLASS_W'(idx_reg) : CLASS_W'(bidx_reg);
            result_reg.best_distance <= better ? cur_min : best_reg;
        end
    end

endmodule

>>> hdl/nearest_palette_hue_classifier.sv
// ----------------------------------------------------------------------------
// nearest_palette_hue_classifier
// Classifies a set of RGB candidates by nearest hue to a palette of references.
// ----------------------------------------------------------------------------
// Front end: accepted items go through the serial hue divider, screened-out ones skip it;
// a new item is taken only when the front end is idle. Back end: each accepted item updates
// the per-reference minima one reference at a time, and a last item adds a search over the
// references. done is one cycle wide, never held off. After reset and each reference write,
// busy stays high while the reference hues are recomputed, one reference at a time.
module nearest_palette_hue_classifier #(
    parameter int NUM_REFS    = npc_pkg::NUM_REFS_DEFAULT,
    parameter int QUEUE_DEPTH = npc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  npc_pkg::item_t                   item,
    output logic                             busy,
    output logic                             done,
    output npc_pkg::result_t                 result,
    input  logic                             cfg_write,
    input  logic [npc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import npc_pkg::*;

    cfg_t             cfg;
    queue_entry_t     push_data, head;
    logic             push, full, pop, empty;
    logic [HUE_W-1:0] hue_table [NUM_REFS];

    assign cfg = '{write: cfg_write, index: cfg_index, data: cfg_data};

    npc_front #(
        .NUM_REFS (NUM_REFS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .hue_table (hue_table)
    );

    npc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    npc_back #(
        .NUM_REFS (NUM_REFS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .hue_table (hue_table),
        .done      (done),
        .result    (result)
    );

endmodule
